// File: sv/assert_macros.svh
// Assertion helper macros used by the checker file vrt_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants for the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DIR_FRAC   = 14;
    localparam int DIST_BITS  = 23;
    localparam int T_BITS     = 32;
    localparam int NUM_BITS   = FRAC_BITS + DIR_FRAC + 1;
    localparam int MAG_BITS   = 17;
    localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);

    localparam logic [DIST_BITS-1:0] MAX_DIST_RESET = 23'd327680;
    localparam logic [T_BITS-1:0]    T_INF          = '1;

    // result kinds
    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;
    localparam logic [1:0] KIND_IDLE  = 2'd3;

    // input ops
    localparam logic OP_START = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    // division jobs per start: next crossing then delta, per axis
    typedef struct packed {
        logic       load;       // capture start request
        logic       div_start;  // launch divider on current job
        logic       div_store;  // write divider result
        logic       step;       // advance walk on non-solid reply
        logic       hit;        // end ray on hit
        logic [1:0] kind;       // result kind to register
        logic       out_load;   // load output register
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic       last_job;
        logic       miss;
        logic       active;
    } t_sts;

endpackage

// File: sv/vrt_div.sv
// ----------------------------------------------------------------------------
// vrt_div
// Restoring divider, one quotient bit per cycle, 32-bit saturated quotient.
// ----------------------------------------------------------------------------
module vrt_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [vrt_pkg::NUM_BITS-1:0]    i_num,
    input  logic [vrt_pkg::MAG_BITS-1:0]    i_den,
    output logic                            o_done,
    output logic [vrt_pkg::T_BITS-1:0]      o_quot
);
    import vrt_pkg::*;

    logic [NUM_BITS-1:0]     r_num, n_num;
    logic [NUM_BITS-1:0]     r_quo, n_quo;
    logic [MAG_BITS:0]       r_rem, n_rem;
    logic [MAG_BITS-1:0]     r_den;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                    r_busy, r_done;
    logic [MAG_BITS:0]       w_trial;

    // one shift-subtract step
    always_comb begin
        w_trial = {r_rem[MAG_BITS-1:0], r_num[NUM_BITS-1]};
        n_num   = {r_num[NUM_BITS-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_quo = {r_quo[NUM_BITS-2:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_quo = {r_quo[NUM_BITS-2:0], 1'b0};
        end
        n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_BITS'(NUM_BITS);
        end else if (r_busy) begin
            r_cnt <= n_cnt;
            if (n_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // zero divisor saturates; numerator is at most 2^30, so the quotient fits
    assign o_done = r_done;
    assign o_quot = (r_den == '0) ? T_INF
                    : {{(T_BITS-NUM_BITS){1'b0}}, r_quo};
endmodule

// File: sv/vrt_datapath.sv
// ----------------------------------------------------------------------------
// vrt_datapath
// Ray state, setup divisions, axis selection and result register.
// ----------------------------------------------------------------------------
module vrt_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vrt_pkg::t_cmd                     i_cmd,
    output vrt_pkg::t_sts                     o_sts,
    input  logic [vrt_pkg::DIST_BITS-1:0]     i_max_distance,
    input  logic [31:0]                       i_origin_x,
    input  logic [31:0]                       i_origin_y,
    input  logic [31:0]                       i_origin_z,
    input  logic [15:0]                       i_dir_x,
    input  logic [15:0]                       i_dir_y,
    input  logic [15:0]                       i_dir_z,
    output logic [1:0]                        o_kind,
    output logic [15:0]                       o_voxel_x,
    output logic [15:0]                       o_voxel_y,
    output logic [15:0]                       o_voxel_z,
    output logic [1:0]                        o_normal_x,
    output logic [1:0]                        o_normal_y,
    output logic [1:0]                        o_normal_z
);
    import vrt_pkg::*;

    logic [FRAC_BITS-1:0]  r_frac [3];
    logic [15:0]           r_dir  [3];
    logic [COORD_BITS-1:0] r_cell [3];
    logic [1:0]            r_step [3];
    logic [T_BITS-1:0]     r_tmax [3];
    logic [T_BITS-1:0]     r_tdel [3];
    logic [1:0]            r_norm [3];
    logic                  r_active;
    logic [2:0]            r_job;      // bit0 picks delta, bits 2:1 axis

    logic [1:0]            w_ax;
    logic [T_BITS:0]       w_sum;
    logic [T_BITS-1:0]     w_next;
    logic [15:0]           w_d;
    logic [MAG_BITS-1:0]   w_mag;
    logic [NUM_BITS-1:0]   w_num;
    logic [FRAC_BITS-1:0]  w_f;
    logic                  w_done;
    logic [T_BITS-1:0]     w_quot;
    logic [31:0]           w_org [3];
    logic [15:0]           w_din [3];

    assign w_org[0] = i_origin_x; assign w_org[1] = i_origin_y; assign w_org[2] = i_origin_z;
    assign w_din[0] = i_dir_x;    assign w_din[1] = i_dir_y;    assign w_din[2] = i_dir_z;

    // divider operands for current job
    always_comb begin
        w_d   = r_dir[r_job[2:1]];
        w_f   = r_frac[r_job[2:1]];
        w_mag = w_d[15] ? (MAG_BITS'(17'h10000) - {1'b0, w_d}) : {1'b0, w_d};
        if (r_job[0])
            w_num = NUM_BITS'(1) << (FRAC_BITS + DIR_FRAC);
        else if (w_d[15])
            w_num = NUM_BITS'({w_f, DIR_FRAC'(0)});
        else
            w_num = (NUM_BITS'(1) << (FRAC_BITS + DIR_FRAC))
                    - NUM_BITS'({w_f, DIR_FRAC'(0)});
    end

    vrt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_mag),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    // smallest crossing, ties go to the later axis (z over y over x)
    always_comb begin
        if (r_tmax[0] < r_tmax[1] && r_tmax[0] < r_tmax[2]) w_ax = 2'd0;
        else if (r_tmax[1] < r_tmax[2])                      w_ax = 2'd1;
        else                                                 w_ax = 2'd2;
        w_sum  = {1'b0, r_tmax[w_ax]} + {1'b0, r_tdel[w_ax]};
        w_next = w_sum[T_BITS] ? T_INF : w_sum[T_BITS-1:0];
    end

    assign o_sts.div_done = w_done;
    assign o_sts.last_job = (r_job == 3'b101);
    assign o_sts.miss     = r_tmax[w_ax] > T_BITS'(i_max_distance);
    assign o_sts.active   = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_job    <= '0;
            for (int a = 0; a < 3; a++) begin
                r_cell[a] <= '0;
                r_step[a] <= '0;
                r_tmax[a] <= T_INF;
                r_tdel[a] <= T_INF;
                r_norm[a] <= '0;
                r_frac[a] <= '0;
                r_dir[a]  <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_active <= 1'b1;
                r_job    <= '0;
                for (int a = 0; a < 3; a++) begin
                    r_cell[a] <= COORD_BITS'(w_org[a][31:FRAC_BITS]);
                    r_frac[a] <= w_org[a][FRAC_BITS-1:0];
                    r_dir[a]  <= w_din[a];
                    r_norm[a] <= '0;
                    r_step[a] <= (w_din[a] == '0) ? 2'b00 : (w_din[a][15] ? 2'b11 : 2'b01);
                end
            end
            if (i_cmd.div_store) begin
                if (r_dir[r_job[2:1]] == '0) begin
                    if (r_job[0]) r_tdel[r_job[2:1]] <= T_INF;
                    else          r_tmax[r_job[2:1]] <= T_INF;
                end else if (r_job[0]) begin
                    r_tdel[r_job[2:1]] <= w_quot;
                end else begin
                    r_tmax[r_job[2:1]] <= w_quot;
                end
                r_job <= r_job[0] ? {r_job[2:1] + 2'd1, 1'b0} : {r_job[2:1], 1'b1};
            end
            if (i_cmd.hit) r_active <= 1'b0;
            if (i_cmd.step) begin
                r_tmax[w_ax] <= w_next;
                r_cell[w_ax] <= r_cell[w_ax] + {{(COORD_BITS-2){r_step[w_ax][1]}}, r_step[w_ax]};
                for (int a = 0; a < 3; a++)
                    r_norm[a] <= (a == int'(w_ax)) ? (2'b00 - r_step[a]) : 2'b00;
                if (o_sts.miss) r_active <= 1'b0;
            end
        end
    end

    // result register; loaded from state as it stands after update
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_kind <= i_cmd.kind;
            if (i_cmd.kind == KIND_QUERY || i_cmd.kind == KIND_HIT) begin
                o_voxel_x <= 16'(r_cell[0]);
                o_voxel_y <= 16'(r_cell[1]);
                o_voxel_z <= 16'(r_cell[2]);
            end else begin
                o_voxel_x <= '0; o_voxel_y <= '0; o_voxel_z <= '0;
            end
            if (i_cmd.kind == KIND_HIT) begin
                o_normal_x <= r_norm[0]; o_normal_y <= r_norm[1]; o_normal_z <= r_norm[2];
            end else begin
                o_normal_x <= '0; o_normal_y <= '0; o_normal_z <= '0;
            end
        end
    end
endmodule

// File: sv/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: request intake, setup divisions, walk step, result handoff.
// ----------------------------------------------------------------------------
module vrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_op,
    input  logic          i_solid,
    output logic          o_valid,
    input  logic          i_ready,
    output vrt_pkg::t_cmd o_cmd,
    input  vrt_pkg::t_sts i_sts
);
    import vrt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIVGO = 6'b000010,
        S_DIVW  = 6'b000100,
        S_STEP  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_kind, n_kind;
    logic       r_solid;
    logic       w_acc;

    assign w_acc   = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_op == OP_START) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIVGO;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_kind          = KIND_QUERY;
                    n_state         = i_sts.last_job ? S_EMIT : S_DIVGO;
                end
            end
            S_STEP: begin
                if (!i_sts.active) begin
                    n_kind = KIND_IDLE;
                end else if (r_solid) begin
                    o_cmd.hit = 1'b1;
                    n_kind    = KIND_HIT;
                end else begin
                    o_cmd.step = 1'b1;
                    n_kind     = i_sts.miss ? KIND_MISS : KIND_QUERY;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.kind     = r_kind;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_QUERY;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_solid <= i_solid;
    end
endmodule

// File: sv/voxel_ray_traversal_top.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top
// 3D DDA voxel walk with start and reply requests.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// in       | input     | i_valid / o_ready    | op, origin_xyz, dir_xyz, solid
// out      | output    | o_valid / i_ready    | kind, voxel_xyz, normal_xyz
// cfg      | input     | i_cfg_valid / o_cfg_ready | max_distance
// A reply goes through the step and emit states before its result is shown;
// a start first runs six divisions one after another on the one shared
// bit-serial divider, then goes through the emit state.
// One request is in flight at a time; the next is taken once the result
// is taken. Reset is synchronous and leaves no ray active.
module voxel_ray_traversal_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic signed [31:0]              i_origin_x,
    input  logic signed [31:0]              i_origin_y,
    input  logic signed [31:0]              i_origin_z,
    input  logic signed [15:0]              i_dir_x,
    input  logic signed [15:0]              i_dir_y,
    input  logic signed [15:0]              i_dir_z,
    input  logic                            i_solid,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_kind,
    output logic signed [15:0]              o_voxel_x,
    output logic signed [15:0]              o_voxel_y,
    output logic signed [15:0]              o_voxel_z,
    output logic signed [1:0]               o_normal_x,
    output logic signed [1:0]               o_normal_y,
    output logic signed [1:0]               o_normal_z,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vrt_pkg::DIST_BITS-1:0]   i_cfg_data
);
    import vrt_pkg::*;

    t_cmd                 w_cmd;
    t_sts                 w_sts;
    logic [DIST_BITS-1:0] r_max_distance;

    // config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)        r_max_distance <= MAX_DIST_RESET;
        else if (i_cfg_valid) r_max_distance <= i_cfg_data;
    end

    vrt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_op   (i_op),
        .i_solid(i_solid),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_cmd  (w_cmd),
        .i_sts  (w_sts)
    );

    vrt_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_max_distance(r_max_distance),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_origin_z    (i_origin_z),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .o_kind        (o_kind),
        .o_voxel_x     (o_voxel_x),
        .o_voxel_y     (o_voxel_y),
        .o_voxel_z     (o_voxel_z),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y),
        .o_normal_z    (o_normal_z)
    );
endmodule

// File: sv/vrt_checker.sv
// ----------------------------------------------------------------------------
// vrt_checker
// Port-level checks on the traversal block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [1:0]  o_normal_x,
    input logic [1:0]  o_normal_y,
    input logic [1:0]  o_normal_z,
    input logic [15:0] o_voxel_x
);
    import vrt_pkg::*;

    // one request in flight: never ready while a result is shown
    `ASSERT_IMPL(a_one_inflight, i_clk, i_rst_n, o_valid, !o_ready)
    // a taken request yields no immediate readiness
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // normals only on hits
    `ASSERT_IMPL(a_normal_hit, i_clk, i_rst_n, o_valid && o_kind != KIND_HIT,
                 o_normal_x == 2'd0 && o_normal_y == 2'd0 && o_normal_z == 2'd0)
    // miss and idle replies carry no voxel (x coordinate checked)
    `ASSERT_IMPL(a_voxel_zero, i_clk, i_rst_n,
                 o_valid && (o_kind == KIND_MISS || o_kind == KIND_IDLE), o_voxel_x == 16'd0)
endmodule

bind voxel_ray_traversal_top vrt_checker u_vrt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_kind    (o_kind),
    .o_normal_x(o_normal_x),
    .o_normal_y(o_normal_y),
    .o_normal_z(o_normal_z),
    .o_voxel_x (o_voxel_x)
);
